@@ rtl/fsr_ht_pkg.sv @@
// Shared types and constants for the sensor message hysteresis trigger.
// Used by the config register file, the trigger cell and the top level.
package fsr_ht_pkg;

    localparam int NUM_SENS = 3;
    localparam int VAL_W    = 14;
    localparam int STAMP_W  = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [VAL_W-1:0]   t_value;
    typedef logic [STAMP_W-1:0] t_stamp;

    // per-sensor trigger state
    typedef struct packed {
        logic pressed;
        logic armed_high;
        logic armed_low;
    } t_trig_state;

    localparam t_trig_state TRIG_RESET = '{pressed: 1'b0, armed_high: 1'b1, armed_low: 1'b0};

    // message status codes
    localparam logic [7:0] STATUS_FIRST = 8'h90;
    localparam logic [7:0] STATUS_LAST  = 8'h95;

    // value decode
    localparam logic [4:0] HI_MASK = 5'd31;

    // thresholds
    localparam t_value CAPTURE_MIN  = 14'd2000;
    localparam t_value LEVEL_MARGIN = 14'd20;
    localparam t_value DELTA_MIN    = 14'd40;
    localparam t_value VALUE_MAX    = 14'h3FFF;

    // register reset values
    localparam t_value LEVEL_RESET = 14'd1500;
    localparam t_value DELTA_RESET = 14'd200;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_THREE = 3'd5;

endpackage

@@ rtl/fsr_ht_cfg.sv @@
// Level and delta register file with write-time clamping.
// Depends on fsr_ht_pkg.
module fsr_ht_cfg (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [fsr_ht_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  fsr_ht_pkg::t_value                       i_cfg_data,
    output fsr_ht_pkg::t_value [fsr_ht_pkg::NUM_SENS-1:0] o_level,
    output fsr_ht_pkg::t_value [fsr_ht_pkg::NUM_SENS-1:0] o_delta
);

    fsr_ht_pkg::t_value [fsr_ht_pkg::NUM_SENS-1:0] r_level;
    fsr_ht_pkg::t_value [fsr_ht_pkg::NUM_SENS-1:0] r_delta;

    logic [fsr_ht_pkg::CFG_IDX_W-1:0] delta_idx;
    logic [1:0]                       lvl_sel;
    logic [1:0]                       dlt_sel;
    logic [fsr_ht_pkg::VAL_W:0]       floor_sum;
    fsr_ht_pkg::t_value               level_floor;
    fsr_ht_pkg::t_value               level_clamped;
    fsr_ht_pkg::t_value               delta_clamped;
    logic                             wr_level;
    logic                             wr_delta;

    assign delta_idx = i_cfg_index - fsr_ht_pkg::CFG_DELTA_ONE;
    assign lvl_sel   = i_cfg_index[1:0];
    assign dlt_sel   = delta_idx[1:0];

    // level floor is the sensor's delta plus margin, saturated
    assign floor_sum   = {1'b0, r_delta[lvl_sel]} + {1'b0, fsr_ht_pkg::LEVEL_MARGIN};
    assign level_floor = (floor_sum > {1'b0, fsr_ht_pkg::VALUE_MAX}) ?
                         fsr_ht_pkg::VALUE_MAX : floor_sum[fsr_ht_pkg::VAL_W-1:0];
    assign level_clamped = (i_cfg_data < level_floor) ? level_floor : i_cfg_data;
    assign delta_clamped = (i_cfg_data < fsr_ht_pkg::DELTA_MIN) ?
                           fsr_ht_pkg::DELTA_MIN : i_cfg_data;

    // index decode
    always_comb begin
        wr_level = 1'b0;
        wr_delta = 1'b0;
        unique case (i_cfg_index) inside
            fsr_ht_pkg::CFG_LEVEL_ONE, fsr_ht_pkg::CFG_LEVEL_TWO,
            fsr_ht_pkg::CFG_LEVEL_THREE: begin
                wr_level = i_cfg_we;
            end
            fsr_ht_pkg::CFG_DELTA_ONE, fsr_ht_pkg::CFG_DELTA_TWO,
            fsr_ht_pkg::CFG_DELTA_THREE: begin
                wr_delta = i_cfg_we;
            end
            default: begin
                wr_level = 1'b0;
                wr_delta = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsr_ht_pkg::NUM_SENS; i++) begin
                r_level[i] <= fsr_ht_pkg::LEVEL_RESET;
                r_delta[i] <= fsr_ht_pkg::DELTA_RESET;
            end
        end else begin
            if (wr_level) begin
                r_level[lvl_sel] <= level_clamped;
            end
            if (wr_delta) begin
                r_delta[dlt_sel] <= delta_clamped;
            end
        end
    end

    assign o_level = r_level;
    assign o_delta = r_delta;

endmodule

@@ rtl/fsr_ht_trigger.sv @@
// Hysteresis trigger cell for one sensor: next state and press/release events.
// Depends on fsr_ht_pkg.
module fsr_ht_trigger (
    input  fsr_ht_pkg::t_value      i_pressure,
    input  fsr_ht_pkg::t_value      i_level,
    input  fsr_ht_pkg::t_value      i_delta,
    input  fsr_ht_pkg::t_trig_state i_state,
    output fsr_ht_pkg::t_trig_state o_state,
    output logic                    o_on,
    output logic                    o_off
);

    // signed compares with one guard bit for L+D and L-D
    logic signed [fsr_ht_pkg::VAL_W+1:0] p_s;
    logic signed [fsr_ht_pkg::VAL_W+1:0] lv_s;
    logic signed [fsr_ht_pkg::VAL_W+1:0] hi_s;
    logic signed [fsr_ht_pkg::VAL_W+1:0] lo_s;
    logic above_hi;
    logic below_lo;
    logic above_lv;
    logic below_lv;
    logic ah1;
    logic al1;

    assign p_s  = $signed({2'b00, i_pressure});
    assign lv_s = $signed({2'b00, i_level});
    assign hi_s = lv_s + $signed({2'b00, i_delta});
    assign lo_s = lv_s - $signed({2'b00, i_delta});

    assign above_hi = p_s > hi_s;
    assign below_lo = p_s < lo_s;
    assign above_lv = p_s > lv_s;
    assign below_lv = p_s < lv_s;

    assign ah1 = i_state.armed_high | above_hi;
    assign al1 = i_state.armed_low | below_lo;

    always_comb begin
        o_state = i_state;
        o_on    = 1'b0;
        o_off   = 1'b0;
        if (i_state.pressed) begin
            o_state.armed_high = ah1;
            if (ah1 && below_lv) begin
                o_state.pressed   = 1'b0;
                o_state.armed_low = 1'b0;
                o_off             = 1'b1;
            end else if (!ah1 && below_lo) begin
                o_state.pressed   = 1'b0;
                o_state.armed_low = 1'b1;
                o_off             = 1'b1;
            end
        end else begin
            o_state.armed_low = al1;
            if (al1 && above_lv) begin
                o_state.pressed    = 1'b1;
                o_state.armed_high = 1'b0;
                o_on               = 1'b1;
            end else if (!al1 && above_hi) begin
                o_state.pressed    = 1'b1;
                o_state.armed_high = 1'b1;
                o_on               = 1'b1;
            end
        end
    end

endmodule

@@ rtl/fsr_message_hysteresis_trigger_core.sv @@
// Sensor message decoder with per-sensor hysteresis press/release trigger.
// A message passes the input register, then the result register, on its way to the result transfer.
// Throughput: one message per cycle while the result stream is not stalled; the
// decode and trigger compares sit between the input register and the result register.
// Reset (i_rst_n low, synchronous): both stages empty, stored positions,
// stamps and pressures zero, triggers released and armed high, levels 1500, deltas 200.
module fsr_message_hysteresis_trigger_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [fsr_ht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  fsr_ht_pkg::t_value                   i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // status_byte[7:0], data_hi[14:8], data_lo[21:15], stamp[53:22], zero pad[55:54]
    input  logic [55:0]                          s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // sensor_index[1:0], decoded_value[15:2], location_captured[16],
    // location[30:17], location_stamp[62:31], on_events[65:63],
    // off_events[68:66], pressed_flags[71:69]
    output logic [71:0]                          m_axis_tdata,
    // is_pressure[0], unknown_status[1]
    output logic [1:0]                           m_axis_tuser,
    // frame_done
    output logic                                 m_axis_tlast
);

    localparam int NS = fsr_ht_pkg::NUM_SENS;

    // input stage
    logic                 r_in_valid;
    logic [7:0]           r_in_status;
    logic [6:0]           r_in_hi;
    logic [6:0]           r_in_lo;
    fsr_ht_pkg::t_stamp   r_in_stamp;

    // result stage
    logic                 r_out_valid;
    logic [71:0]          r_out_tdata;
    logic [1:0]           r_out_tuser;
    logic                 r_out_tlast;

    // sensor state
    fsr_ht_pkg::t_value      [NS-1:0] r_position;
    fsr_ht_pkg::t_stamp      [NS-1:0] r_pos_stamp;
    fsr_ht_pkg::t_value      [NS-1:0] r_pressure;
    fsr_ht_pkg::t_trig_state [NS-1:0] r_trig;

    fsr_ht_pkg::t_value      [NS-1:0] level;
    fsr_ht_pkg::t_value      [NS-1:0] delta;
    fsr_ht_pkg::t_value      [NS-1:0] trig_pressure;
    fsr_ht_pkg::t_trig_state [NS-1:0] trig_next;
    logic                    [NS-1:0] trig_on;
    logic                    [NS-1:0] trig_off;

    logic                 advance;
    logic                 known;
    logic [7:0]           status_ofs;
    logic [1:0]           sens;
    logic                 is_p;
    logic                 frame;
    logic                 capture;
    fsr_ht_pkg::t_value   val;
    fsr_ht_pkg::t_trig_state [NS-1:0] n_trig;
    logic [NS-1:0]        pressed_now;
    logic [NS-1:0]        on_ev;
    logic [NS-1:0]        off_ev;
    fsr_ht_pkg::t_value   loc;
    fsr_ht_pkg::t_stamp   loc_stamp;
    logic [71:0]          n_out_tdata;
    logic [1:0]           n_out_tuser;
    logic                 n_out_tlast;

    fsr_ht_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_level     (level),
        .o_delta     (delta)
    );

    // handshake: stage 1 moves when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_status <= s_axis_tdata[7:0];
            r_in_hi     <= s_axis_tdata[14:8];
            r_in_lo     <= s_axis_tdata[21:15];
            r_in_stamp  <= s_axis_tdata[53:22];
        end
    end

    // message decode
    assign known      = (r_in_status >= fsr_ht_pkg::STATUS_FIRST) &&
                        (r_in_status <= fsr_ht_pkg::STATUS_LAST);
    assign status_ofs = r_in_status - fsr_ht_pkg::STATUS_FIRST;
    assign sens       = status_ofs[2:1];
    assign is_p       = status_ofs[0];
    assign frame      = r_in_status == fsr_ht_pkg::STATUS_LAST;
    assign val        = {r_in_hi[4:0] & fsr_ht_pkg::HI_MASK, r_in_lo, 2'b00};
    assign capture    = known && is_p && (val > fsr_ht_pkg::CAPTURE_MIN);

    // trigger cells see the pressure as stored by this message
    for (genvar g = 0; g < NS; g++) begin : g_trig
        assign trig_pressure[g] = (is_p && (sens == 2'(g))) ? val : r_pressure[g];

        fsr_ht_trigger u_trig (
            .i_pressure (trig_pressure[g]),
            .i_level    (level[g]),
            .i_delta    (delta[g]),
            .i_state    (r_trig[g]),
            .o_state    (trig_next[g]),
            .o_on       (trig_on[g]),
            .o_off      (trig_off[g])
        );

        assign pressed_now[g] = n_trig[g].pressed;
    end

    assign n_trig    = (known && frame) ? trig_next : r_trig;
    assign on_ev     = (known && frame) ? trig_on : '0;
    assign off_ev    = (known && frame) ? trig_off : '0;
    assign loc       = capture ? r_position[sens] : '0;
    assign loc_stamp = capture ? r_pos_stamp[sens] : '0;

    // result packing
    always_comb begin
        if (known) begin
            n_out_tdata = {pressed_now, off_ev, on_ev, loc_stamp, loc, capture, val, sens};
            n_out_tuser = {1'b0, is_p};
            n_out_tlast = frame;
        end else begin
            n_out_tdata = {pressed_now, 69'd0};
            n_out_tuser = 2'b10;
            n_out_tlast = 1'b0;
        end
    end

    // sensor state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_position[i]  <= '0;
                r_pos_stamp[i] <= '0;
                r_pressure[i]  <= '0;
                r_trig[i]      <= fsr_ht_pkg::TRIG_RESET;
            end
        end else if (advance && known) begin
            if (is_p) begin
                r_pressure[sens] <= val;
            end else begin
                r_position[sens]  <= val;
                r_pos_stamp[sens] <= r_in_stamp;
            end
            r_trig <= n_trig;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
            r_out_tlast <= n_out_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign m_axis_tlast  = r_out_tlast;

`ifndef ASSERT_OFF
    // a sensor never presses and releases in the same frame
    a_events_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[65:63] & m_axis_tdata[68:66]) == 3'd0))
        else $error("press and release on the same sensor");

    // a press leaves the sensor pressed, a release leaves it released
    a_events_match_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((m_axis_tdata[65:63] & ~m_axis_tdata[71:69]) == 3'd0) &&
                           ((m_axis_tdata[68:66] & m_axis_tdata[71:69]) == 3'd0)))
        else $error("event bits disagree with pressed flags");

    // unknown status carries no frame close and no events
    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (!m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata[68:63] == 6'd0)))
        else $error("unknown status result carries frame data");

    // trigger state only moves on a frame-closing message
    a_trig_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && known && frame) |=> $stable(r_trig))
        else $error("trigger state changed outside a frame close");

    // an item in the input stage with an empty result stage lands next cycle
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("result stage failed to load");
`endif

endmodule

@@ tb/fsr_ht_trigger_check.sv @@
// Transfer monitor and result predictor for the sensor message hysteresis trigger.
// Depends on fsr_ht_pkg; mirrors config writes, predicts each input transfer and
// compares every result transfer field by field against the oldest prediction.
module fsr_ht_trigger_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fsr_ht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  fsr_ht_pkg::t_value               i_cfg_data,
    input  logic                             i_in_tvalid,
    input  logic                             i_in_tready,
    // status_byte, data_hi, data_lo, stamp, zero pad
    input  logic [55:0]                      i_in_tdata,
    input  logic                             i_out_tvalid,
    input  logic                             i_out_tready,
    // sensor_index, decoded_value, location_captured, location, location_stamp,
    // on_events, off_events, pressed_flags
    input  logic [71:0]                      i_out_tdata,
    // is_pressure, unknown_status
    input  logic [1:0]                       i_out_tuser,
    input  logic                             i_out_tlast,
    output int                               o_fail_count,
    output int                               o_results_due
);

    typedef enum {EV_NONE, EV_PRESS, EV_RELEASE} t_trig_event;

    typedef struct packed {
        logic [1:0]         sensor_index;
        logic               is_pressure;
        fsr_ht_pkg::t_value decoded_value;
        logic               loc_captured;
        fsr_ht_pkg::t_value location;
        fsr_ht_pkg::t_stamp location_stamp;
        logic [2:0]         on_events;
        logic [2:0]         off_events;
        logic [2:0]         pressed_flags;
        logic               frame_done;
        logic               unknown_status;
    } t_msg_result;

    // mirrored block state
    fsr_ht_pkg::t_value      level_q    [fsr_ht_pkg::NUM_SENS];
    fsr_ht_pkg::t_value      delta_q    [fsr_ht_pkg::NUM_SENS];
    fsr_ht_pkg::t_value      position_q [fsr_ht_pkg::NUM_SENS];
    fsr_ht_pkg::t_stamp      pos_stamp_q[fsr_ht_pkg::NUM_SENS];
    fsr_ht_pkg::t_value      pressure_q [fsr_ht_pkg::NUM_SENS];
    fsr_ht_pkg::t_trig_state trig_q     [fsr_ht_pkg::NUM_SENS];

    t_msg_result msg_results_due[$];
    int          fail_total;

    function automatic logic [2:0] pressed_now();
        logic [2:0] b;
        b = '0;
        for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) b[s] = trig_q[s].pressed;
        return b;
    endfunction

    // hysteresis trigger of one sensor, signed compares
    function automatic t_trig_event run_hysteresis(int s);
        int p;
        int lv;
        int d;
        p  = pressure_q[s];
        lv = level_q[s];
        d  = delta_q[s];
        if (trig_q[s].pressed) begin
            if (p > lv + d) trig_q[s].armed_high = 1'b1;
            if (trig_q[s].armed_high && p < lv) begin
                trig_q[s].pressed   = 1'b0;
                trig_q[s].armed_low = 1'b0;
                return EV_RELEASE;
            end else if (!trig_q[s].armed_high && p < lv - d) begin
                trig_q[s].pressed   = 1'b0;
                trig_q[s].armed_low = 1'b1;
                return EV_RELEASE;
            end
        end else begin
            if (p < lv - d) trig_q[s].armed_low = 1'b1;
            if (trig_q[s].armed_low && p > lv) begin
                trig_q[s].pressed    = 1'b1;
                trig_q[s].armed_high = 1'b0;
                return EV_PRESS;
            end else if (!trig_q[s].armed_low && p > lv + d) begin
                trig_q[s].pressed    = 1'b1;
                trig_q[s].armed_high = 1'b1;
                return EV_PRESS;
            end
        end
        return EV_NONE;
    endfunction

    // decode one message, update state, build the expected result
    function automatic t_msg_result predict_message(logic [55:0] d);
        logic [7:0]         st;
        logic [7:0]         offs;
        fsr_ht_pkg::t_value val;
        fsr_ht_pkg::t_stamp stamp;
        t_msg_result        r;
        int                 s;
        t_trig_event        ev;
        st    = d[7:0];
        val   = {d[12:8], d[21:15], 2'b00};
        stamp = d[53:22];
        r     = '0;
        if (st < fsr_ht_pkg::STATUS_FIRST || st > fsr_ht_pkg::STATUS_LAST) begin
            r.unknown_status = 1'b1;
            r.pressed_flags  = pressed_now();
            return r;
        end
        offs = st - fsr_ht_pkg::STATUS_FIRST;
        s    = offs[2:1];
        r.sensor_index  = offs[2:1];
        r.is_pressure   = offs[0];
        r.decoded_value = val;
        if (!offs[0]) begin
            position_q[s]  = val;
            pos_stamp_q[s] = stamp;
        end else begin
            pressure_q[s] = val;
            if (val > fsr_ht_pkg::CAPTURE_MIN) begin
                r.loc_captured   = 1'b1;
                r.location       = position_q[s];
                r.location_stamp = pos_stamp_q[s];
            end
            // frame close evaluates all three triggers
            if (st == fsr_ht_pkg::STATUS_LAST) begin
                for (int i = 0; i < fsr_ht_pkg::NUM_SENS; i++) begin
                    ev = run_hysteresis(i);
                    if (ev == EV_PRESS)   r.on_events[i]  = 1'b1;
                    if (ev == EV_RELEASE) r.off_events[i] = 1'b1;
                end
                r.frame_done = 1'b1;
            end
        end
        r.pressed_flags = pressed_now();
        return r;
    endfunction

    function automatic void write_register(logic [fsr_ht_pkg::CFG_IDX_W-1:0] idx,
                                           fsr_ht_pkg::t_value v);
        int floor_v;
        int s;
        case (idx)
            fsr_ht_pkg::CFG_LEVEL_ONE, fsr_ht_pkg::CFG_LEVEL_TWO,
            fsr_ht_pkg::CFG_LEVEL_THREE: begin
                s       = idx - fsr_ht_pkg::CFG_LEVEL_ONE;
                floor_v = int'(delta_q[s]) + int'(fsr_ht_pkg::LEVEL_MARGIN);
                if (floor_v > int'(fsr_ht_pkg::VALUE_MAX)) floor_v = fsr_ht_pkg::VALUE_MAX;
                level_q[s] = (int'(v) < floor_v) ? fsr_ht_pkg::t_value'(floor_v) : v;
            end
            fsr_ht_pkg::CFG_DELTA_ONE, fsr_ht_pkg::CFG_DELTA_TWO,
            fsr_ht_pkg::CFG_DELTA_THREE: begin
                s          = idx - fsr_ht_pkg::CFG_DELTA_ONE;
                delta_q[s] = (v < fsr_ht_pkg::DELTA_MIN) ? fsr_ht_pkg::DELTA_MIN : v;
            end
            default: ;
        endcase
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want === got) return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // monitor both channels and the config port
    always @(posedge i_clk) begin : monitor
        t_msg_result want;
        t_msg_result got;
        int          bad;
        if (!i_rst_n) begin
            for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) begin
                level_q[s]     = fsr_ht_pkg::LEVEL_RESET;
                delta_q[s]     = fsr_ht_pkg::DELTA_RESET;
                position_q[s]  = '0;
                pos_stamp_q[s] = '0;
                pressure_q[s]  = '0;
                trig_q[s]      = fsr_ht_pkg::TRIG_RESET;
            end
            msg_results_due.delete();
        end else begin
            if (i_cfg_we) write_register(i_cfg_index, i_cfg_data);
            if (i_in_tvalid && i_in_tready)
                msg_results_due.push_back(predict_message(i_in_tdata));
            if (i_out_tvalid && i_out_tready) begin
                got.sensor_index   = i_out_tdata[1:0];
                got.decoded_value  = i_out_tdata[15:2];
                got.loc_captured   = i_out_tdata[16];
                got.location       = i_out_tdata[30:17];
                got.location_stamp = i_out_tdata[62:31];
                got.on_events      = i_out_tdata[65:63];
                got.off_events     = i_out_tdata[68:66];
                got.pressed_flags  = i_out_tdata[71:69];
                got.is_pressure    = i_out_tuser[0];
                got.unknown_status = i_out_tuser[1];
                got.frame_done     = i_out_tlast;
                if (msg_results_due.size() == 0) begin
                    $display("%0t: result transfer, expected none, actual tdata %h",
                             $time, i_out_tdata);
                    fail_total = fail_total + 1;
                end else begin
                    want = msg_results_due.pop_front();
                    bad  = 0;
                    bad += field_differs("sensor_index", 32'(want.sensor_index),
                                         32'(got.sensor_index));
                    bad += field_differs("is_pressure", 32'(want.is_pressure),
                                         32'(got.is_pressure));
                    bad += field_differs("decoded_value", 32'(want.decoded_value),
                                         32'(got.decoded_value));
                    bad += field_differs("location_captured", 32'(want.loc_captured),
                                         32'(got.loc_captured));
                    bad += field_differs("location", 32'(want.location),
                                         32'(got.location));
                    bad += field_differs("location_stamp", want.location_stamp,
                                         got.location_stamp);
                    bad += field_differs("on_events", 32'(want.on_events),
                                         32'(got.on_events));
                    bad += field_differs("off_events", 32'(want.off_events),
                                         32'(got.off_events));
                    bad += field_differs("pressed_flags", 32'(want.pressed_flags),
                                         32'(got.pressed_flags));
                    bad += field_differs("frame_done", 32'(want.frame_done),
                                         32'(got.frame_done));
                    bad += field_differs("unknown_status", 32'(want.unknown_status),
                                         32'(got.unknown_status));
                    if (bad != 0) fail_total = fail_total + 1;
                end
            end
        end
        o_results_due <= msg_results_due.size();
        o_fail_count  <= fail_total;
    end

endmodule

@@ tb/testbench.sv @@
// Top level of the sensor message hysteresis trigger testbench: clock, reset,
// config phases, message stimulus with bursty sender and stalling receiver, verdict.
// Depends on fsr_ht_pkg, the core and fsr_ht_trigger_check.
module testbench;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_MSGS    = 240;

    // indexes with no register behind them
    localparam logic [fsr_ht_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [fsr_ht_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [fsr_ht_pkg::CFG_IDX_W-1:0] LEVEL_IDX [fsr_ht_pkg::NUM_SENS] =
        '{fsr_ht_pkg::CFG_LEVEL_ONE, fsr_ht_pkg::CFG_LEVEL_TWO, fsr_ht_pkg::CFG_LEVEL_THREE};
    localparam logic [fsr_ht_pkg::CFG_IDX_W-1:0] DELTA_IDX [fsr_ht_pkg::NUM_SENS] =
        '{fsr_ht_pkg::CFG_DELTA_ONE, fsr_ht_pkg::CFG_DELTA_TWO, fsr_ht_pkg::CFG_DELTA_THREE};

    typedef enum {RX_OPEN, RX_BUSY, RX_CHOKED} t_rx_mode;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [fsr_ht_pkg::CFG_IDX_W-1:0] i_cfg_index;
    fsr_ht_pkg::t_value               i_cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [55:0]                      s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [71:0]                      m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             m_axis_tlast;

    int fail_count;
    int results_due;
    int idle_cycles = 0;
    int burst_left;
    int msgs_sent;
    // rough copy of the programmed levels, only used to aim pressures at the band
    int level_aim [fsr_ht_pkg::NUM_SENS];
    int delta_aim [fsr_ht_pkg::NUM_SENS];

    fsr_message_hysteresis_trigger_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fsr_ht_trigger_check u_trig_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .i_out_tlast   (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: stall pattern switches between open, busy and choked stretches
    initial begin : receiver
        t_rx_mode mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                left = $urandom_range(16, 96);
            end else begin
                left = left - 1;
            end
            case (mode)
                RX_OPEN: m_axis_tready <= 1'b1;
                RX_BUSY: m_axis_tready <= ($urandom_range(0, 9) < 7);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one message transfer; a new burst may open with a gap
    task automatic send_msg(input logic [7:0] st, input logic [6:0] hi, input logic [6:0] lo,
                            input fsr_ht_pkg::t_stamp stamp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        s_axis_tdata  <= {2'b00, stamp, lo, hi, st};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        msgs_sent = msgs_sent + 1;
    endtask

    // encode a value; the two unused data_hi bits are random
    task automatic send_value(input logic [7:0] st, input int v, input fsr_ht_pkg::t_stamp stamp);
        logic [11:0] code;
        code = 12'(v >> 2);
        send_msg(st, {2'($urandom), code[11:7]}, code[6:0], stamp);
    endtask

    task automatic cfg_write(input logic [fsr_ht_pkg::CFG_IDX_W-1:0] idx,
                             input fsr_ht_pkg::t_value v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) begin
            if (idx == LEVEL_IDX[s]) level_aim[s] = v;
            if (idx == DELTA_IDX[s]) delta_aim[s] = v;
        end
        @(posedge i_clk);
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_phase(input int ph);
        for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) begin
            case (ph)
                // both below their floors
                0: begin
                    cfg_write(DELTA_IDX[s], '0);
                    cfg_write(LEVEL_IDX[s], '0);
                end
                // largest delta, level floor saturates
                1: begin
                    cfg_write(DELTA_IDX[s], fsr_ht_pkg::VALUE_MAX);
                    cfg_write(LEVEL_IDX[s], 14'($urandom_range(0, 3000)));
                end
                // largest level, smallest useful delta
                2: begin
                    cfg_write(DELTA_IDX[s], fsr_ht_pkg::DELTA_MIN);
                    cfg_write(LEVEL_IDX[s], fsr_ht_pkg::VALUE_MAX);
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        cfg_write(LEVEL_IDX[s], ($urandom_range(0, 1) == 0) ?
                                  14'($urandom) : 14'($urandom_range(500, 8000)));
                        cfg_write(DELTA_IDX[s], ($urandom_range(0, 9) == 0) ?
                                  14'($urandom) : 14'($urandom_range(0, 3000)));
                    end else begin
                        cfg_write(DELTA_IDX[s], ($urandom_range(0, 9) == 0) ?
                                  14'($urandom) : 14'($urandom_range(0, 3000)));
                        cfg_write(LEVEL_IDX[s], ($urandom_range(0, 1) == 0) ?
                                  14'($urandom) : 14'($urandom_range(500, 8000)));
                    end
                end
            endcase
        end
        cfg_write(CFG_SPARE_LO, 14'($urandom));
        cfg_write(CFG_SPARE_HI, 14'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // pressure aimed at the hysteresis band, at the capture edge, or anywhere
    function automatic int pick_pressure(input int s);
        int v;
        int span;
        int off;
        case ($urandom_range(0, 7))
            0, 1:    v = $urandom_range(0, 16383);
            2:       v = 2000 + 4 * ($urandom_range(0, 2) - 1);
            default: begin
                span = 2 * delta_aim[s] + 40;
                off  = $urandom_range(0, 2 * span);
                v    = level_aim[s] + off - span;
            end
        endcase
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        return v;
    endfunction

    task automatic random_frame();
        int kind;
        int n;
        int st_off;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            // well-formed frame: position then pressure per sensor, closed by 0x95
            for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) begin
                send_value(8'(fsr_ht_pkg::STATUS_FIRST + 2 * s), $urandom_range(0, 16383),
                           $urandom);
                send_value(8'(fsr_ht_pkg::STATUS_FIRST + 2 * s + 1), pick_pressure(s),
                           $urandom);
            end
        end else if (kind < 92) begin
            // broken frame: sensor messages in random order and number
            n = $urandom_range(1, 5);
            repeat (n) begin
                st_off = $urandom_range(0, 5);
                send_value(8'(fsr_ht_pkg::STATUS_FIRST + st_off), pick_pressure(st_off / 2),
                           $urandom);
            end
        end else begin
            // noise: any status byte, any data
            send_msg(8'($urandom), 7'($urandom), 7'($urandom), $urandom);
        end
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        burst_left = 0;
        msgs_sent  = 0;
        for (int s = 0; s < fsr_ht_pkg::NUM_SENS; s++) begin
            level_aim[s] = fsr_ht_pkg::LEVEL_RESET;
            delta_aim[s] = fsr_ht_pkg::DELTA_RESET;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with reset levels 1500 and deltas 200
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd3, 2004, 32'h1234_5678); // capture, no position
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd1, 2000, 32'hFFFF_FFFF); // exactly 2000
        send_msg(8'h00, 7'h7F, 7'h7F, $urandom);                          // unknown status bytes
        send_msg(8'hFF, 7'h7F, 7'h7F, $urandom);
        send_msg(fsr_ht_pkg::STATUS_FIRST - 8'd1, 7'h00, 7'h00, $urandom);
        send_msg(fsr_ht_pkg::STATUS_LAST + 8'd1, 7'h55, 7'h2A, $urandom);
        send_msg(fsr_ht_pkg::STATUS_FIRST, 7'h7F, 7'h7F, 32'hFFFF_FFFF);  // largest position
        send_msg(fsr_ht_pkg::STATUS_FIRST + 8'd2, 7'h00, 7'h00, 32'h0000_0000);
        send_msg(fsr_ht_pkg::STATUS_FIRST + 8'd4, 7'h6A, 7'h55, 32'h5A5A_5A5A);
        send_msg(fsr_ht_pkg::STATUS_FIRST + 8'd1, 7'h7F, 7'h7F, 32'h0);   // largest pressure
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd3, 0, 32'h0);
        send_value(fsr_ht_pkg::STATUS_LAST, 1800, 32'h0);                 // presses above band
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd1, 1600, 32'h0);
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd3, 1600, 32'h0);
        send_value(fsr_ht_pkg::STATUS_LAST, 1400, 32'h0);   // armed press, armed-high release
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd1, 1400, 32'h0);
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd3, 1400, 32'h0);
        send_value(fsr_ht_pkg::STATUS_LAST, 1200, 32'h0);                 // sensor 0 releases, sensor 2 arms low
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd1, 1800, 32'h0);
        send_value(fsr_ht_pkg::STATUS_FIRST + 8'd3, 1200, 32'h0);
        send_value(fsr_ht_pkg::STATUS_LAST, 1600, 32'h0);                 // release below band
        send_value(fsr_ht_pkg::STATUS_LAST, 2004, 32'h0);                 // capture on close

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            program_phase(ph);
            msgs_sent = 0;
            while (msgs_sent < PHASE_MSGS) random_frame();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
